[hw/rtl/pac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants
// Register map, reset values, datapath widths and the command bundle passed
// from the sequencer to the datapath of the altitude controller.
// ----------------------------------------------------------------------------
package pac_pkg;

  localparam int HEIGHT_BITS_DEF = 12;

  localparam int GAIN_W  = 24;
  localparam int HALF_W  = 16;
  localparam int DUTY_W  = 7;
  localparam int SP_W    = 7;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 64;
  localparam int DACC_W  = 68;
  localparam int SUM_W   = 48;
  localparam int LAST_W  = 16;
  localparam int DUTY_Q_W = ACC_W - 24;

  localparam logic signed [DACC_W-1:0] D_LIM = 68'sh0_4000_0000_0000_0000;

  localparam logic [GAIN_W-1:0] KP_RST     = 24'd32768;
  localparam logic [GAIN_W-1:0] KI_RST     = 24'd2621;
  localparam logic [GAIN_W-1:0] KD_RST     = 24'd45875;
  localparam logic [HALF_W-1:0] SCALE_RST  = 16'd3174;
  localparam logic [HALF_W-1:0] RATE_RST   = 16'd160;
  localparam logic [HALF_W-1:0] PERIOD_RST = 16'd410;
  localparam logic [DUTY_W-1:0] DMAX_RST   = 7'd75;
  localparam logic [DUTY_W-1:0] DMIN_RST   = 7'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_SCALE  = 3'd3,
    REG_RATE   = 3'd4,
    REG_PERIOD = 3'd5,
    REG_DMAX   = 3'd6,
    REG_DMIN   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_proportional;
    logic [GAIN_W-1:0] gain_integral;
    logic [GAIN_W-1:0] gain_derivative;
    logic [HALF_W-1:0] height_scale;
    logic [HALF_W-1:0] sample_rate;
    logic [HALF_W-1:0] sample_period;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_P   = 3'd0,
    MS_IH  = 3'd1,
    MS_IL  = 3'd2,
    MS_D1  = 3'd3,
    MS_D2H = 3'd4,
    MS_D2L = 3'd5,
    MS_INT = 3'd6
  } mul_sel_e;

  typedef enum logic [2:0] {
    AO_NONE     = 3'd0,
    AO_LOAD_P   = 3'd1,
    AO_ADD_IH   = 3'd2,
    AO_ADD_IL   = 3'd3,
    AO_LOAD_D   = 3'd4,
    AO_ADD_D    = 3'd5,
    AO_ADD_DSAT = 3'd6
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     trunc;
    logic     clamp;
    logic     commit;
  } cmd_t;

endpackage

[hw/rtl/pac_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_cfg: configuration registers
// Write-only register file for gains, scaling and duty limits.
// ----------------------------------------------------------------------------
module pac_cfg import pac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:     cfg_d.gain_proportional = cfg_wdata_i;
        REG_KI:     cfg_d.gain_integral     = cfg_wdata_i;
        REG_KD:     cfg_d.gain_derivative   = cfg_wdata_i;
        REG_SCALE:  cfg_d.height_scale      = cfg_wdata_i[HALF_W-1:0];
        REG_RATE:   cfg_d.sample_rate       = cfg_wdata_i[HALF_W-1:0];
        REG_PERIOD: cfg_d.sample_period     = cfg_wdata_i[HALF_W-1:0];
        REG_DMAX:   cfg_d.duty_max          = cfg_wdata_i[DUTY_W-1:0];
        REG_DMIN:   cfg_d.duty_min          = cfg_wdata_i[DUTY_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_proportional <= KP_RST;
      cfg_q.gain_integral     <= KI_RST;
      cfg_q.gain_derivative   <= KD_RST;
      cfg_q.height_scale      <= SCALE_RST;
      cfg_q.sample_rate       <= RATE_RST;
      cfg_q.sample_period     <= PERIOD_RST;
      cfg_q.duty_max          <= DMAX_RST;
      cfg_q.duty_min          <= DMIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/pac_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_dpath: PID datapath
// Error former, one shared 33x24 multiplier with registered product, term
// accumulator, truncation, clamp, integral and previous-error state.
// ----------------------------------------------------------------------------
module pac_dpath import pac_pkg::*; #(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  input  logic [HEIGHT_BITS-1:0] measured_height_i,
  input  logic [SP_W-1:0]        height_setpoint_i,
  input  logic [HEIGHT_BITS-1:0] ground_level_i,
  output logic [DUTY_W-1:0]      duty_percent_o,
  output logic                   clamped_o
);

  localparam int ERR_W  = ((HEIGHT_BITS + 9 > 24) ? HEIGHT_BITS + 9 : 24) + 1;
  localparam int EINT_W = ERR_W - 8;

  // error former
  logic signed [HEIGHT_BITS:0] delta;
  logic [22:0]                 sprod;
  logic signed [ERR_W-1:0]     err_d, err_q;

  assign delta = $signed({1'b0, measured_height_i}) - $signed({1'b0, ground_level_i});
  assign sprod = 23'(cfg_i.height_scale) * 23'(height_setpoint_i);
  assign err_d = ERR_W'($signed({delta, 8'b0})) + ERR_W'($signed({1'b0, sprod}));

  // state
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [LAST_W-1:0] last_q, last_d;

  // multiplier
  logic signed [MUL_A_W-1:0] err_ext, last_ext, diff, mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod_full;
  logic signed [PROD_W-1:0]  prod_q;
  logic [23:0]               d1l_q;

  assign err_ext  = MUL_A_W'(err_q);
  assign last_ext = MUL_A_W'($signed({last_q, 8'b0}));
  assign diff     = err_ext - last_ext;

  always_comb begin
    mul_a = err_ext;
    mul_b = cfg_i.gain_proportional;
    case (cmd_i.mul_sel)
      MS_P: begin
        mul_a = err_ext;
        mul_b = cfg_i.gain_proportional;
      end
      MS_IH: begin
        mul_a = MUL_A_W'($signed(sum_q[SUM_W-1:16]));
        mul_b = cfg_i.gain_integral;
      end
      MS_IL: begin
        mul_a = $signed(MUL_A_W'(sum_q[15:0]));
        mul_b = cfg_i.gain_integral;
      end
      MS_D1: begin
        mul_a = diff;
        mul_b = cfg_i.gain_derivative;
      end
      MS_D2H: begin
        mul_a = prod_q[PROD_W-1:24];
        mul_b = MUL_B_W'(cfg_i.sample_rate);
      end
      MS_D2L: begin
        mul_a = $signed(MUL_A_W'(d1l_q));
        mul_b = MUL_B_W'(cfg_i.sample_rate);
      end
      MS_INT: begin
        mul_a = err_ext;
        mul_b = MUL_B_W'(cfg_i.sample_period);
      end
      default: begin
        mul_a = err_ext;
        mul_b = cfg_i.gain_proportional;
      end
    endcase
  end

  assign prod_full = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  // accumulators
  logic signed [ACC_W-1:0]  acc_q, acc_d, dsat, acc_bias;
  logic signed [DACC_W-1:0] dacc_q, dacc_d;

  always_comb begin
    if (dacc_q > D_LIM) begin
      dsat = D_LIM[ACC_W-1:0];
    end else if (dacc_q < -D_LIM) begin
      dsat = ACC_W'(-D_LIM);
    end else begin
      dsat = dacc_q[ACC_W-1:0];
    end
  end

  always_comb begin
    acc_d  = acc_q;
    dacc_d = dacc_q;
    case (cmd_i.acc_op)
      AO_NONE:     acc_d = acc_q;
      AO_LOAD_P:   acc_d = ACC_W'(prod_q);
      AO_ADD_IH:   acc_d = acc_q + ACC_W'(prod_q);
      AO_ADD_IL:   acc_d = acc_q + $signed(ACC_W'(prod_q[39:16]));
      AO_LOAD_D:   dacc_d = $signed({prod_q[43:0], 24'b0});
      AO_ADD_D:    dacc_d = dacc_q + $signed(DACC_W'(prod_q[39:0]));
      AO_ADD_DSAT: acc_d = acc_q + dsat;
      default:     acc_d = acc_q;
    endcase
  end

  // truncation toward zero and clamp
  logic signed [DUTY_Q_W-1:0] duty_q, max_s, min_s;
  logic [DUTY_W-1:0]          res_q, res_d;
  logic                       hit_q, hit_d;

  assign acc_bias = acc_q + (acc_q[ACC_W-1] ? ACC_W'(24'hFF_FFFF) : ACC_W'(0));
  assign max_s    = $signed(DUTY_Q_W'(cfg_i.duty_max));
  assign min_s    = $signed(DUTY_Q_W'(cfg_i.duty_min));

  always_comb begin
    if (duty_q >= max_s) begin
      res_d = cfg_i.duty_max;
      hit_d = 1'b1;
    end else if (duty_q <= min_s) begin
      res_d = cfg_i.duty_min;
      hit_d = 1'b1;
    end else begin
      res_d = duty_q[DUTY_W-1:0];
      hit_d = 1'b0;
    end
  end

  // integral and previous error update
  logic signed [ERR_W-1:0]   err_bias;
  logic signed [EINT_W-1:0]  eint;
  logic signed [MUL_A_W-1:0] eint_ext;
  logic signed [SUM_W:0]     sum_n;

  assign err_bias = err_q + (err_q[ERR_W-1] ? ERR_W'(255) : ERR_W'(0));
  assign eint     = err_bias[ERR_W-1:8];
  assign eint_ext = MUL_A_W'(eint);

  always_comb begin
    if (eint_ext > MUL_A_W'(32767)) begin
      last_d = 16'sh7FFF;
    end else if (eint_ext < -MUL_A_W'(32768)) begin
      last_d = 16'sh8000;
    end else begin
      last_d = eint_ext[LAST_W-1:0];
    end
  end

  assign sum_n = {sum_q[SUM_W-1], sum_q} + prod_q[SUM_W:0];

  always_comb begin
    if (sum_n[SUM_W] != sum_n[SUM_W-1]) begin
      sum_d = sum_n[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_d = sum_n[SUM_W-1:0];
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else if (cmd_i.commit) begin
      last_q <= last_d;
      if (!hit_q) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= err_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_full;
    end
    if (cmd_i.mul_en && (cmd_i.mul_sel == MS_D2H)) begin
      d1l_q <= prod_q[23:0];
    end
    acc_q  <= acc_d;
    dacc_q <= dacc_d;
    if (cmd_i.trunc) begin
      duty_q <= acc_bias[ACC_W-1:24];
    end
    if (cmd_i.clamp) begin
      res_q <= res_d;
      hit_q <= hit_d;
    end
    if (cmd_i.commit) begin
      duty_percent_o <= res_q;
      clamped_o      <= hit_q;
    end
  end

endmodule

[hw/rtl/pac_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pac_ctrl: sequencer
// One-hot state machine that steps the datapath through the PID terms and
// owns the request handshakes on both streams.
// ----------------------------------------------------------------------------
module pac_ctrl import pac_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'h001,
    ST_MP    = 12'h002,
    ST_MIH   = 12'h004,
    ST_MIL   = 12'h008,
    ST_MD1   = 12'h010,
    ST_MD2H  = 12'h020,
    ST_MD2L  = 12'h040,
    ST_DADD  = 12'h080,
    ST_DSAT  = 12'h100,
    ST_TRUNC = 12'h200,
    ST_CLAMP = 12'h400,
    ST_DONE  = 12'h800
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        valid_q, valid_d;
  logic        slot_free;

  assign slot_free     = !valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = valid_q;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MS_P;
    cmd_o.acc_op   = AO_NONE;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MP;
        end
      end
      ST_MP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_P;
        state_d       = ST_MIH;
      end
      ST_MIH: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_IH;
        cmd_o.acc_op  = AO_LOAD_P;
        state_d       = ST_MIL;
      end
      ST_MIL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_IL;
        cmd_o.acc_op  = AO_ADD_IH;
        state_d       = ST_MD1;
      end
      ST_MD1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_D1;
        cmd_o.acc_op  = AO_ADD_IL;
        state_d       = ST_MD2H;
      end
      ST_MD2H: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_D2H;
        state_d       = ST_MD2L;
      end
      ST_MD2L: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_D2L;
        cmd_o.acc_op  = AO_LOAD_D;
        state_d       = ST_DADD;
      end
      ST_DADD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_INT;
        cmd_o.acc_op  = AO_ADD_D;
        state_d       = ST_DSAT;
      end
      ST_DSAT: begin
        cmd_o.acc_op = AO_ADD_DSAT;
        state_d      = ST_TRUNC;
      end
      ST_TRUNC: begin
        cmd_o.trunc = 1'b1;
        state_d     = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.commit) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_MP)
    else $error("accepted request did not start the sequence");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside the final step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && valid_q && !m_axis_tready |=> state_q == ST_DONE && valid_q)
    else $error("pending result overwritten");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !valid_q |=> state_q == ST_IDLE && valid_q)
    else $error("free output slot not filled");

endmodule

[hw/rtl/pid_altitude_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_altitude_controller: PID altitude loop with conditional integration
// A new request is accepted only after the previous result has been
// committed to the output; the single shared 33x24 multiplier forms the P, I,
// D and integral-step products in turn.
// Reset: gains and limits return to defaults, integral and previous error
// clear to zero, no result pending.
// ----------------------------------------------------------------------------
module pid_altitude_controller import pac_pkg::*; #(
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [IDX_W-1:0]              cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // measured_height, height_setpoint, ground_level, zero pad
  input  logic [((2*HEIGHT_BITS+SP_W+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty_percent, clamped
  output logic [7:0]                    m_axis_tdata
);

  cfg_t cfg;
  cmd_t cmd;

  logic [DUTY_W-1:0] duty;
  logic              clamped;

  pac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pac_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd)
  );

  pac_dpath #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .measured_height_i (s_axis_tdata[HEIGHT_BITS-1:0]),
    .height_setpoint_i (s_axis_tdata[HEIGHT_BITS+SP_W-1:HEIGHT_BITS]),
    .ground_level_i    (s_axis_tdata[2*HEIGHT_BITS+SP_W-1:HEIGHT_BITS+SP_W]),
    .duty_percent_o    (duty),
    .clamped_o         (clamped)
  );

  assign m_axis_tdata = {clamped, duty};

endmodule

[tb/pid_altitude_controller_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_altitude_controller_tb: self-checking bench for the altitude PID loop
// Control samples go in on the slave stream and duty results come back on the
// master stream. A local copy of the controller state (integral, previous
// error) and of the register file predicts each duty and clamp flag. Results
// are compared in order. The run steps through several register settings:
// defaults, zero and full-scale gains, crossed limits and integral
// saturation. Random stalls are applied on both stream sides.
// ----------------------------------------------------------------------------
module pid_altitude_controller_tb;
  import pac_pkg::*;

  localparam int HB    = HEIGHT_BITS_DEF;
  localparam int TD_W  = ((2*HB+SP_W+7)/8)*8;
  localparam int LIMIT = 400000;
  localparam longint SUM_HI = (longint'(1) <<< 47) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< 47);
  localparam logic [127:0] D_CAP = 128'd1 << 62;

  typedef struct packed {
    logic [HB-1:0]   meas;
    logic [SP_W-1:0] sp;
    logic [HB-1:0]   gnd;
  } sample_t;

  typedef struct {
    sample_t smp;
    bit      drain;
  } request_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              clamped;
  } duty_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TD_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;

  pid_altitude_controller #(.HEIGHT_BITS(HB)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cfg_t     ctl_cfg;
  int       prev_err;
  longint   integ_sum;

  request_t pending[$];
  duty_t    duty_due[$];
  request_t head;
  bit       in_acc;
  int       src_idle_pct;
  int       snk_idle_pct;
  int       n_sent;
  int       n_done;
  int       n_clamped;
  int       mismatches;
  int       cycles;

  // One control step of the loop; updates integral and previous error.
  function automatic duty_t pid_step(sample_t s);
    longint     err, pterm, iterm, dterm, diff, mag, kdr, total, duty, nsum, eint;
    logic [127:0] dprod;
    duty_t      r;
    err = (longint'(s.meas) - longint'(s.gnd)) * 256
        + longint'(ctl_cfg.height_scale) * longint'(s.sp);
    pterm = longint'(ctl_cfg.gain_proportional) * err;
    iterm = longint'(ctl_cfg.gain_integral) * (integ_sum >>> 16)
          + ((longint'(ctl_cfg.gain_integral) * longint'(integ_sum[15:0])) >>> 16);
    diff = err - longint'(prev_err) * 256;
    mag = (diff < 0) ? -diff : diff;
    kdr = longint'(ctl_cfg.gain_derivative) * longint'(ctl_cfg.sample_rate);
    dprod = {64'd0, mag} * {64'd0, kdr};
    if (dprod > D_CAP) dprod = D_CAP;
    dterm = longint'(dprod[63:0]);
    if (diff < 0) dterm = -dterm;
    total = pterm + iterm + dterm;
    duty = total / 64'sd16777216;
    r.clamped = 1'b1;
    if (duty >= longint'(ctl_cfg.duty_max)) begin
      duty = longint'(ctl_cfg.duty_max);
    end else if (duty <= longint'(ctl_cfg.duty_min)) begin
      duty = longint'(ctl_cfg.duty_min);
    end else begin
      nsum = integ_sum + err * longint'(ctl_cfg.sample_period);
      if (nsum > SUM_HI) nsum = SUM_HI;
      if (nsum < SUM_LO) nsum = SUM_LO;
      integ_sum = nsum;
      r.clamped = 1'b0;
    end
    eint = err / 256;
    if (eint > 32767) eint = 32767;
    if (eint < -32768) eint = -32768;
    prev_err = int'(eint);
    r.duty = duty[DUTY_W-1:0];
    return r;
  endfunction

  function automatic logic [TD_W-1:0] pack_sample(sample_t s);
    return {{(TD_W-2*HB-SP_W){1'b0}}, s.gnd, s.sp, s.meas};
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_acc) begin
        if (pending.size() != 0 && !(pending[0].drain && n_sent != n_done)
            && $urandom_range(99) >= src_idle_pct) begin
          head = pending.pop_front();
          n_sent++;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_sample(head.smp);
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= TD_W'($urandom);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    sample_t s;
    duty_t   exp_r;
    in_acc = s_axis_tvalid && s_axis_tready;
    if (in_acc) begin
      s.meas = s_axis_tdata[HB-1:0];
      s.sp   = s_axis_tdata[HB+SP_W-1:HB];
      s.gnd  = s_axis_tdata[2*HB+SP_W-1:HB+SP_W];
      duty_due.push_back(pid_step(s));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      n_done++;
      if (duty_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing pending: duty %0d clamped %0b",
                   $realtime, m_axis_tdata[6:0], m_axis_tdata[7]);
      end else begin
        exp_r = duty_due.pop_front();
        if (exp_r.clamped) n_clamped++;
        if (m_axis_tdata[6:0] !== exp_r.duty || m_axis_tdata[7] !== exp_r.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d: duty exp %0d got %0d, clamped exp %0b got %0b",
                     $realtime, n_done, exp_r.duty, m_axis_tdata[6:0],
                     exp_r.clamped, m_axis_tdata[7]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycles, n_done, n_sent);
      $display("pid_altitude_controller: mismatch");
      $finish;
    end
  end

  task automatic set_reg(reg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    case (idx)
      REG_KP:     ctl_cfg.gain_proportional = val[GAIN_W-1:0];
      REG_KI:     ctl_cfg.gain_integral     = val[GAIN_W-1:0];
      REG_KD:     ctl_cfg.gain_derivative   = val[GAIN_W-1:0];
      REG_SCALE:  ctl_cfg.height_scale      = val[HALF_W-1:0];
      REG_RATE:   ctl_cfg.sample_rate       = val[HALF_W-1:0];
      REG_PERIOD: ctl_cfg.sample_period     = val[HALF_W-1:0];
      REG_DMAX:   ctl_cfg.duty_max          = val[DUTY_W-1:0];
      REG_DMIN:   ctl_cfg.duty_min          = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(int unsigned kp, int unsigned ki, int unsigned kd,
                          int unsigned scale, int unsigned rate, int unsigned period,
                          int unsigned dmax, int unsigned dmin);
    set_reg(REG_KP, kp);
    set_reg(REG_KI, ki);
    set_reg(REG_KD, kd);
    set_reg(REG_SCALE, scale);
    set_reg(REG_RATE, rate);
    set_reg(REG_PERIOD, period);
    set_reg(REG_DMAX, dmax);
    set_reg(REG_DMIN, dmin);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_sample(int meas, int sp, int gnd, bit drain);
    request_t r;
    r.smp.meas = meas[HB-1:0];
    r.smp.sp   = sp[SP_W-1:0];
    r.smp.gnd  = gnd[HB-1:0];
    r.drain    = drain;
    pending.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || n_sent != n_done) @(negedge clk_i);
  endtask

  // Mostly slow trajectories around the set-point (so the loop leaves the
  // clamps and integrates), the rest fully random samples.
  task automatic queue_samples(int count, int off_lim);
    int run_left, sp, gnd, meas;
    run_left = 0;
    sp = 0;
    gnd = 0;
    meas = 0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0) begin
        add_sample($urandom_range(4095), $urandom_range(127), $urandom_range(4095),
                   k == 0 || $urandom_range(39) == 0);
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(12, 4);
          case ($urandom_range(3))
            0:       sp = 0;
            1:       sp = $urandom_range(127, 101);
            default: sp = $urandom_range(100);
          endcase
          gnd = $urandom_range(4095);
          meas = gnd - (int'(ctl_cfg.height_scale) * sp) / 256
               + int'($urandom_range(2*off_lim)) - off_lim;
        end else if ($urandom_range(2) == 0) begin
          meas += $urandom_range(1) ? 1 : -1;
        end
        if (meas < 0) meas = 0;
        if (meas > 4095) meas = 4095;
        run_left--;
        add_sample(meas, sp, gnd, k == 0 || $urandom_range(39) == 0);
      end
    end
  endtask

  initial begin
    ctl_cfg = '{gain_proportional: KP_RST, gain_integral: KI_RST,
                gain_derivative: KD_RST, height_scale: SCALE_RST,
                sample_rate: RATE_RST, sample_period: PERIOD_RST,
                duty_max: DMAX_RST, duty_min: DMIN_RST};
    prev_err = 0;
    integ_sum = 0;
    src_idle_pct = 12;
    snk_idle_pct = 68;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, sign of the error, steady samples, alternating bits
    add_sample(0, 0, 0, 0);
    add_sample(4095, 0, 0, 0);
    add_sample(0, 0, 4095, 0);
    add_sample(4095, 127, 0, 0);
    add_sample(0, 127, 4095, 0);
    add_sample(0, 100, 4095, 0);
    add_sample(1100, 0, 1000, 0);
    add_sample(1100, 0, 1000, 0);
    add_sample(1100, 0, 1000, 0);
    add_sample(1180, 0, 1000, 0);
    add_sample(1180, 0, 1000, 0);
    add_sample(1100, 100, 2240, 0);
    add_sample(1100, 100, 2240, 0);
    add_sample(2240, 0, 2100, 0);
    add_sample(2240, 0, 2100, 0);
    add_sample(12'hAAA, 7'h55, 12'h555, 0);
    add_sample(12'h555, 7'h2A, 12'hAAA, 0);
    add_sample(900, 0, 1000, 0);
    add_sample(900, 0, 1000, 0);
    wait_idle();

    queue_samples(80, 200);
    wait_idle();
    // unit P gain, no derivative, zero sample rate, full integration step
    load_cfg(65536, 32768, 0, 256, 0, 65535, 100, 0);
    queue_samples(80, 120);
    wait_idle();

    src_idle_pct = 68;
    snk_idle_pct = 12;
    // every register but the sample period at its top (no integration step); derivative saturates
    load_cfg(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 0, 127, 127);
    queue_samples(60, 200);
    wait_idle();
    // crossed limits: duty_min above duty_max
    load_cfg(0, 0, 1000, 3174, 1, 1000, 10, 90);
    queue_samples(60, 200);
    wait_idle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    // drive the integral into positive saturation with a constant sample
    load_cfg(100, 0, 0, 65535, 160, 65535, 100, 0);
    for (int k = 0; k < 235; k++) add_sample(4095, 127, 0, 0);
    wait_idle();
    // saturated integral seen through the smallest nonzero integral gain
    load_cfg(32768, 1, 45875, 3174, 160, 410, 75, 20);
    queue_samples(20, 150);
    wait_idle();
    load_cfg(32768, 0, 4096, 3174, 16, 410, 75, 20);
    queue_samples(60, 200);
    wait_idle();

    repeat (30) @(posedge clk_i);
    mismatches += duty_due.size();
    $display("%0d control samples over 7 register settings, %0d duty results checked",
             n_sent, n_done);
    $display("%0d results at a limit, %0d integrating", n_clamped, n_done - n_clamped);
    if (mismatches == 0) begin
      $display("pid_altitude_controller: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("pid_altitude_controller: mismatch");
    end
    $finish;
  end

endmodule
